>>> rtl/otq_pkg.sv
// ----------------------------------------------------------------------------
// otq_pkg: shared types and constants of the ordered timer queue
// Payload structs, command and result codes, sequencer states.
// ----------------------------------------------------------------------------
package otq_pkg;

  localparam int unsigned CAPACITY_DEF = 16;
  localparam int unsigned MAX_FIRE     = 16;
  localparam logic [15:0] MIN_REARM_RST = 16'd100;
  localparam logic [62:0] DEADLINE_MAX = {63{1'b1}};
  localparam logic [39:0] DELAY_MAX    = {40{1'b1}};

  typedef enum logic [0:0] {
    CMD_ADD  = 1'b0,
    CMD_TICK = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_ACK   = 2'd0,
    KIND_FIRED = 2'd1,
    KIND_IDLE  = 2'd2,
    KIND_RSVD  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD_SCAN,
    ST_TICK_SCAN,
    ST_REARM,
    ST_NEXT_SCAN,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic        command;
    logic [15:0] timer_tag;
    logic [62:0] expire_time;
    logic [31:0] interval_us;
    logic [62:0] now_time;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] fired_tag;
    logic        last;
    logic        earliest_changed;
    logic        overflow;
    logic        next_valid;
    logic [62:0] next_deadline;
    logic [39:0] rearm_delay;
  } out_word_t;

  // strict order: deadline, then tag, then slot
  function automatic logic key_before(logic [62:0] da, logic [15:0] ta, logic [62:0] db,
                                      logic [15:0] tb);
    logic r;
    if (da != db) r = da < db;
    else          r = ta < tb;
    return r;
  endfunction

endpackage

>>> rtl/ordered_timer_queue_core.sv
// ----------------------------------------------------------------------------
// ordered_timer_queue_core: deadline-ordered timer store
// Adds timers and expires due ones in deadline order with one shared compare.
// ----------------------------------------------------------------------------
// Usage: present an input word on in_valid_i/in_word_i; it is taken when
// in_stall_o is low. An add stores a timer (or flags overflow when full) and
// returns one acknowledge word. A tick returns one word per due timer in
// deadline/tag/slot order (at most 16, last marked) or one "nothing due" word.
// Every result carries the earliest pending deadline and the rearm delay,
// clamped below by min_rearm_us (written through cfg_we_i/cfg_data_i, by the
// user only while idle; the block does not enforce this) and saturated at 40 bits.
// Sequence: a shared compare/select unit walks one slot per cycle. An add runs
// a free-slot scan, a next-deadline scan, one output word and an idle state
// before the next accept. A tick runs one slot scan per fired timer plus a
// final empty scan (none after the 16th), one rearm step per fired timer, a
// next-deadline scan, its output words and an idle state; the slot scans set
// the rate. One item is in work at a time; in_stall_o is high until its last
// word is taken. When out_stall_i is high the output word holds and the
// sequencer waits. Reset clears all valid bits and sets min_rearm_us to 100;
// no clearing pass is needed.
module ordered_timer_queue_core #(
  parameter int unsigned CAPACITY = otq_pkg::CAPACITY_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  otq_pkg::in_word_t   in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output otq_pkg::out_word_t  out_word_o,
  input  logic                cfg_we_i,
  input  logic [15:0]         cfg_data_i
);

  localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned NW = $clog2(otq_pkg::MAX_FIRE + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(CAPACITY - 1);

  otq_pkg::state_e state_q, state_d;
  logic [15:0]         min_q;
  logic [CAPACITY-1:0] valid_q, taken_q;
  logic [62:0]         dl_q  [CAPACITY];
  logic [31:0]         iv_q  [CAPACITY];
  logic [15:0]         tag_q [CAPACITY];
  otq_pkg::in_word_t   cmd_q;
  logic [IW-1:0]       idx_q;
  logic                best_ok_q;
  logic [IW-1:0]       best_q;
  logic                free_ok_q;
  logic [IW-1:0]       free_q;
  logic [IW-1:0]       fired_q [otq_pkg::MAX_FIRE];
  logic [NW-1:0]       nfire_q, k_q;
  logic                ovf_q, chg_q;

  // shared compare unit: candidate slot idx_q against current best
  logic [62:0] cd, bd;
  logic [15:0] ct, bt;
  logic        c_elig, c_wins;
  always_comb begin
    cd = dl_q[idx_q];
    ct = tag_q[idx_q];
    bd = dl_q[best_q];
    bt = tag_q[best_q];
    c_elig = valid_q[idx_q];
    if (state_q == otq_pkg::ST_TICK_SCAN)
      c_elig = c_elig && !taken_q[idx_q] && (cd <= cmd_q.now_time);
    c_wins = c_elig && (!best_ok_q || otq_pkg::key_before(cd, ct, bd, bt));
  end

  logic [63:0] sum;
  assign sum = {1'b0, cmd_q.now_time} + {32'd0, iv_q[fired_q[k_q[NW-2:0]]]};

  logic [62:0] diff;
  logic [39:0] dly;
  always_comb begin
    diff = (bd > cmd_q.now_time) ? bd - cmd_q.now_time : 63'd0;
    if (diff[62:40] != '0) dly = otq_pkg::DELAY_MAX;
    else                   dly = diff[39:0];
    if (dly < {24'd0, min_q}) dly = {24'd0, min_q};
  end

  logic scan_end;
  assign scan_end = (idx_q == LAST_IDX);
  assign in_stall_o = (state_q != otq_pkg::ST_IDLE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      otq_pkg::ST_IDLE:      if (in_valid_i) state_d = (in_word_i.command == otq_pkg::CMD_ADD) ?
                               otq_pkg::ST_ADD_SCAN : otq_pkg::ST_TICK_SCAN;
      otq_pkg::ST_ADD_SCAN:  if (scan_end) state_d = otq_pkg::ST_NEXT_SCAN;
      otq_pkg::ST_TICK_SCAN: begin
        if (scan_end && (!(best_ok_q || c_wins) ||
                         nfire_q == NW'(otq_pkg::MAX_FIRE - 1)))
          state_d = (nfire_q == '0 && !c_wins) ? otq_pkg::ST_NEXT_SCAN : otq_pkg::ST_REARM;
      end
      otq_pkg::ST_REARM:     if (k_q == nfire_q - NW'(1)) state_d = otq_pkg::ST_NEXT_SCAN;
      otq_pkg::ST_NEXT_SCAN: if (scan_end) state_d = otq_pkg::ST_EMIT;
      otq_pkg::ST_EMIT:      if (!out_stall_i && out_word_o.last) state_d = otq_pkg::ST_IDLE;
      default:               state_d = otq_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= otq_pkg::ST_IDLE;
      min_q   <= otq_pkg::MIN_REARM_RST;
      valid_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) min_q <= cfg_data_i;
      if (state_q == otq_pkg::ST_ADD_SCAN && scan_end) begin
        // commit add using free slot found during scan (include last slot)
        if (free_ok_q || !valid_q[idx_q]) valid_q[free_ok_q ? free_q : idx_q] <= 1'b1;
      end
      if (state_q == otq_pkg::ST_REARM && iv_q[fired_q[k_q[NW-2:0]]] == '0)
        valid_q[fired_q[k_q[NW-2:0]]] <= 1'b0;
    end
  end

  logic [IW-1:0] fslot;
  assign fslot = free_ok_q ? free_q : idx_q;
  logic [IW-1:0] rs;
  assign rs = fired_q[k_q[NW-2:0]];

  always_ff @(posedge clk_i) begin
    case (state_q)
      otq_pkg::ST_IDLE: begin
        cmd_q <= in_word_i;
        idx_q <= '0; best_ok_q <= 1'b0; best_q <= '0;
        free_ok_q <= 1'b0; nfire_q <= '0; k_q <= '0; taken_q <= '0;
      end
      otq_pkg::ST_ADD_SCAN: begin
        if (c_wins) begin best_ok_q <= 1'b1; best_q <= idx_q; end
        if (!free_ok_q && !valid_q[idx_q]) begin free_ok_q <= 1'b1; free_q <= idx_q; end
        idx_q <= scan_end ? '0 : idx_q + IW'(1);
        if (scan_end) begin
          ovf_q <= !(free_ok_q || !valid_q[idx_q]);
          chg_q <= (free_ok_q || !valid_q[idx_q]) &&
                   (!(best_ok_q || c_wins) ||
                    cmd_q.expire_time < (c_wins ? cd : bd));
          if (free_ok_q || !valid_q[idx_q]) begin
            dl_q[fslot]  <= cmd_q.expire_time;
            iv_q[fslot]  <= cmd_q.interval_us;
            tag_q[fslot] <= cmd_q.timer_tag;
          end
          best_ok_q <= 1'b0; best_q <= '0;
        end
      end
      otq_pkg::ST_TICK_SCAN: begin
        if (c_wins) begin best_ok_q <= 1'b1; best_q <= idx_q; end
        idx_q <= scan_end ? '0 : idx_q + IW'(1);
        if (scan_end) begin
          best_ok_q <= 1'b0; best_q <= '0;
          if (best_ok_q || c_wins) begin
            fired_q[nfire_q[NW-2:0]] <= c_wins ? idx_q : best_q;
            taken_q[c_wins ? idx_q : best_q] <= 1'b1;
            nfire_q <= nfire_q + NW'(1);
          end
        end
      end
      otq_pkg::ST_REARM: begin
        if (iv_q[rs] != '0) dl_q[rs] <= sum[63] ? otq_pkg::DEADLINE_MAX : sum[62:0];
        k_q <= (state_d == otq_pkg::ST_REARM) ? k_q + NW'(1) : '0;
      end
      otq_pkg::ST_NEXT_SCAN: begin
        if (c_wins) begin best_ok_q <= 1'b1; best_q <= idx_q; end
        if (scan_end) idx_q <= '0; else idx_q <= idx_q + IW'(1);
      end
      otq_pkg::ST_EMIT: begin
        if (!out_stall_i) k_q <= k_q + NW'(1);
      end
      default: ;
    endcase
  end

  assign out_valid_o = (state_q == otq_pkg::ST_EMIT);

  always_comb begin
    out_word_o = '0;
    if (cmd_q.command == otq_pkg::CMD_ADD) begin
      out_word_o.kind = otq_pkg::KIND_ACK;
      out_word_o.earliest_changed = chg_q;
      out_word_o.overflow = ovf_q;
      out_word_o.last = 1'b1;
    end else if (nfire_q == '0) begin
      out_word_o.kind = otq_pkg::KIND_IDLE;
      out_word_o.last = 1'b1;
    end else begin
      out_word_o.kind = otq_pkg::KIND_FIRED;
      out_word_o.fired_tag = tag_q[rs];
      out_word_o.last = (k_q == nfire_q - NW'(1));
    end
    out_word_o.next_valid = best_ok_q;
    if (best_ok_q) begin
      out_word_o.next_deadline = bd;
      out_word_o.rearm_delay = dly;
    end
  end

endmodule

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: bench for the ordered timer queue core
// Drives add and tick words through the valid/stall handshake. A predictor
// keeps its own timer store and min rearm setting and queues the expected
// result words; a checker compares each taken output word field by field.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned SLOTS = 16;
  localparam int unsigned LIMIT = 600000;
  localparam logic [63:0] SAT63 = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] SAT40 = 64'h00FF_FFFF_FFFF;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  otq_pkg::in_word_t   in_word = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  otq_pkg::out_word_t  out_word;
  logic                cfg_we = 1'b0;
  logic [15:0]         cfg_data = '0;

  ordered_timer_queue_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word),
    .cfg_we_i    (cfg_we),
    .cfg_data_i  (cfg_data)
  );

  // predictor state
  logic        slot_used [SLOTS];
  logic [62:0] slot_due [SLOTS];
  logic [31:0] slot_period [SLOTS];
  logic [15:0] slot_tag [SLOTS];
  logic [15:0] min_rearm;

  otq_pkg::out_word_t pending_words [$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned burst_left = 0;
  bit          hold_req = 1'b0;
  bit          stall_free = 1'b0;
  logic [62:0] clock_us = 63'd1000;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic bit orders_first(int a, int b);
    if (slot_due[a] != slot_due[b]) return slot_due[a] < slot_due[b];
    if (slot_tag[a] != slot_tag[b]) return slot_tag[a] < slot_tag[b];
    return a < b;
  endfunction

  function automatic int head_slot();
    int best;
    best = -1;
    for (int i = 0; i < SLOTS; i++)
      if (slot_used[i] && (best < 0 || orders_first(i, best))) best = i;
    return best;
  endfunction

  function automatic otq_pkg::out_word_t with_next(otq_pkg::out_word_t r,
                                                   logic [62:0] now_v);
    int s;
    logic [63:0] dly;
    s = head_slot();
    r.next_valid = 1'b0;
    r.next_deadline = '0;
    r.rearm_delay = '0;
    if (s >= 0) begin
      dly = (slot_due[s] > now_v) ? {1'b0, slot_due[s]} - {1'b0, now_v} : 64'd0;
      if (dly < {48'd0, min_rearm}) dly = {48'd0, min_rearm};
      if (dly > SAT40) dly = SAT40;
      r.next_valid = 1'b1;
      r.next_deadline = slot_due[s];
      r.rearm_delay = dly[39:0];
    end
    return r;
  endfunction

  task automatic predict_word(otq_pkg::in_word_t w);
    otq_pkg::out_word_t r;
    int free_slot, best, n;
    bit taken [SLOTS];
    int fired [$];
    logic [63:0] nd;
    r = '0;
    if (w.command == otq_pkg::CMD_ADD) begin
      free_slot = -1;
      for (int i = SLOTS - 1; i >= 0; i--) if (!slot_used[i]) free_slot = i;
      if (free_slot < 0) begin
        r.overflow = 1'b1;
      end else begin
        best = head_slot();
        r.earliest_changed = (best < 0) || (w.expire_time < slot_due[best]);
        slot_used[free_slot] = 1'b1;
        slot_due[free_slot] = w.expire_time;
        slot_period[free_slot] = w.interval_us;
        slot_tag[free_slot] = w.timer_tag;
      end
      r.kind = otq_pkg::KIND_ACK;
      r.last = 1'b1;
      pending_words.push_back(with_next(r, w.now_time));
      return;
    end
    foreach (taken[i]) taken[i] = 1'b0;
    n = 0;
    while (n < otq_pkg::MAX_FIRE) begin
      best = -1;
      for (int i = 0; i < SLOTS; i++)
        if (slot_used[i] && !taken[i] && slot_due[i] <= w.now_time &&
            (best < 0 || orders_first(i, best))) best = i;
      if (best < 0) break;
      taken[best] = 1'b1;
      fired.push_back(best);
      n++;
    end
    if (n == 0) begin
      r.kind = otq_pkg::KIND_IDLE;
      r.last = 1'b1;
      pending_words.push_back(with_next(r, w.now_time));
      return;
    end
    foreach (fired[k]) begin
      r.fired_tag = slot_tag[fired[k]];
      pending_words.push_back(r);
      r = '0;
      if (slot_period[fired[k]] != 0) begin
        nd = {1'b0, w.now_time} + {32'd0, slot_period[fired[k]]};
        slot_due[fired[k]] = (nd > SAT63) ? SAT63[62:0] : nd[62:0];
      end else begin
        slot_used[fired[k]] = 1'b0;
      end
    end
    // fill kind, last and the post-tick next fields on the queued words
    for (int k = 0; k < n; k++) begin
      r = pending_words[pending_words.size() - n + k];
      r.kind = otq_pkg::KIND_FIRED;
      r.last = (k == n - 1);
      pending_words[pending_words.size() - n + k] = with_next(r, w.now_time);
    end
  endtask

  task automatic report(string field, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at cycle %0d", field, got, want, cycles);
    errors++;
  endtask

  always @(posedge clk_i) begin
    otq_pkg::out_word_t e;
    if (rst_ni && out_valid && !out_stall) begin
      if (pending_words.size() == 0) begin
        report("unexpected word", 0, 0);
      end else begin
        e = pending_words.pop_front();
        if (out_word.kind != e.kind) report("kind", out_word.kind, e.kind);
        if (out_word.fired_tag != e.fired_tag)
          report("fired_tag", out_word.fired_tag, e.fired_tag);
        if (out_word.last != e.last) report("last", out_word.last, e.last);
        if (out_word.earliest_changed != e.earliest_changed)
          report("earliest_changed", out_word.earliest_changed, e.earliest_changed);
        if (out_word.overflow != e.overflow)
          report("overflow", out_word.overflow, e.overflow);
        if (out_word.next_valid != e.next_valid)
          report("next_valid", out_word.next_valid, e.next_valid);
        if (out_word.next_deadline != e.next_deadline)
          report("next_deadline", out_word.next_deadline, e.next_deadline);
        if (out_word.rearm_delay != e.rearm_delay)
          report("rearm_delay", out_word.rearm_delay, e.rearm_delay);
      end
    end
  end

  // receiver: random stalls, stall-free stretches, and a long hold on request
  initial begin
    int hold_cnt;
    hold_cnt = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req && hold_cnt < 400) begin
        hold_cnt++;
        out_stall <= 1'b1;
      end else begin
        if (hold_req) begin
          hold_req = 1'b0;
          hold_cnt = 0;
        end
        if ($urandom_range(0, 99) == 0) stall_free = ~stall_free;
        out_stall <= stall_free ? 1'b0 : ($urandom_range(0, 2) == 0);
      end
    end
  end

  // take one word; leave valid high only when the burst goes on
  task automatic send_word(otq_pkg::in_word_t w);
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk_i); while (in_stall);
    predict_word(w);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = $urandom_range(0, 8);
    end
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_min_rearm(logic [15:0] v);
    wait_drain();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    min_rearm = v;
    @(posedge clk_i);
  endtask

  function automatic otq_pkg::in_word_t add_word(logic [15:0] tag, logic [62:0] due,
                                                 logic [31:0] period, logic [62:0] now_v);
    otq_pkg::in_word_t w;
    w = '0;
    w.command = otq_pkg::CMD_ADD;
    w.timer_tag = tag;
    w.expire_time = due;
    w.interval_us = period;
    w.now_time = now_v;
    return w;
  endfunction

  function automatic otq_pkg::in_word_t tick_word(logic [62:0] now_v);
    otq_pkg::in_word_t w;
    w = '0;
    w.command = otq_pkg::CMD_TICK;
    w.now_time = now_v;
    return w;
  endfunction

  function automatic logic [62:0] rand63();
    return 63'({$urandom, $urandom});
  endfunction

  // empty store, extremes, ties, saturation, a full store and overflow
  task automatic test_directed();
    send_word(tick_word(63'd0));
    send_word(add_word(16'hFFFF, otq_pkg::DEADLINE_MAX, 32'hFFFF_FFFF, 63'd0));
    send_word(add_word(16'h0000, 63'd500, 32'd0, 63'd450));
    send_word(add_word(16'h0005, 63'd500, 32'd100, 63'd600));
    send_word(add_word(16'h0005, 63'd500, 32'd0, 63'd0));
    send_word(add_word(16'h0003, 63'd700, 32'hFFFF_FFFF, 63'd10));
    send_word(tick_word(63'd499));
    send_word(tick_word(63'd500));
    send_word(tick_word(otq_pkg::DEADLINE_MAX));
    send_word(tick_word(otq_pkg::DEADLINE_MAX));
    send_word(tick_word(63'd0));
    write_min_rearm(16'd0);
    for (int i = 0; i < 17; i++)
      send_word(add_word(16'(i * 7), 63'd2000 - 63'(i % 3), 32'(i % 2), 63'd1999));
    send_word(tick_word(63'd2000));
    send_word(tick_word(63'd4000));
  endtask

  task automatic test_min_rearm_extremes();
    write_min_rearm(16'hFFFF);
    send_word(add_word(16'h1234, 63'd10, 32'd0, 63'd0));
    send_word(tick_word(63'd5));
    send_word(tick_word(63'd100000));
    write_min_rearm(otq_pkg::MIN_REARM_RST);
  endtask

  // adds near the running clock with ticks that advance it; rare wide values
  task automatic run_random(int count);
    otq_pkg::in_word_t w;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) < 6) begin
        w = add_word(16'($urandom), clock_us + $urandom_range(0, 600),
                     ($urandom_range(0, 2) == 0) ? 32'd0 : $urandom_range(1, 400),
                     clock_us);
        if ($urandom_range(0, 9) == 0) begin
          w.expire_time = rand63();
          w.interval_us = $urandom;
          w.now_time = rand63();
        end
      end else begin
        clock_us = clock_us + $urandom_range(0, 300);
        w = tick_word(clock_us);
      end
      send_word(w);
    end
  endtask

  // long receiver hold while items keep coming, then a full drain
  task automatic test_backpressure();
    hold_req = 1'b1;
    run_random(20);
    wait_drain();
  endtask

  initial begin
    foreach (slot_used[i]) begin
      slot_used[i] = 1'b0;
      slot_due[i] = '0;
      slot_period[i] = '0;
      slot_tag[i] = '0;
    end
    min_rearm = otq_pkg::MIN_REARM_RST;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_min_rearm_extremes();
    run_random(30);
    write_min_rearm(16'd37);
    test_backpressure();
    run_random(30);
    wait_drain();
    repeat (50) @(posedge clk_i);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> ordered_timer_queue_core.f
rtl/otq_pkg.sv
rtl/ordered_timer_queue_core.sv
bench/tb_top.sv
